>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the stable priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int ID_W      = 16;
  localparam int PRI_W     = 3;
  localparam int OCC_W     = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SERVE
  } cell_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // broadcast from the control to all cells
  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    new_entry;
  } cell_ctl_t;

endpackage : spq_pkg
`default_nettype wire

>>> hw/rtl/spq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channels of the stable priority queue
// depends on spq_pkg
interface spq_in_if
  import spq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [ID_W-1:0]  entry_id;
  logic [PRI_W-1:0] entry_priority;

  modport source (output valid, opcode, entry_id, entry_priority, input ready);
  modport sink   (input valid, opcode, entry_id, entry_priority, output ready);
endinterface : spq_in_if

interface spq_out_if
  import spq_pkg::*;
();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [ID_W-1:0]  served_id;
  logic [PRI_W-1:0] served_priority;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, served_id, served_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, served_id, served_priority, occupancy,
                  output ready);
endinterface : spq_out_if
`default_nettype wire

>>> hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one slot of the sorted chain: holds an entry, shifts right on insert,
// left on serve; depends on spq_pkg
module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire entry_t           left_entry,
  input  wire logic             left_keep,
  input  wire entry_t           right_entry,
  output entry_t                entry_q,
  output logic                  keep
);

  entry_t entry_r;
  entry_t entry_nxt;

  // occupied and sorting at or ahead of the new entry
  assign keep = (CNT_W'(IDX) < count) && (entry_r.pri <= ctl.new_entry.pri);

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (keep) entry_nxt = entry_r;
        else if (left_keep) entry_nxt = ctl.new_entry;
        else entry_nxt = left_entry;
      end
      CMD_SERVE: entry_nxt = right_entry;
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule : spq_cell
`default_nettype wire

>>> hw/rtl/stable_priority_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// top level of the stable priority queue: control, count and the cell chain
// depends on spq_pkg, spq_if, spq_cell
//
//  channel  dir  handshake             payload
//  in_ch    in   valid/ready           opcode, entry_id, entry_priority
//  out_ch   out  valid/ready           status, served_id, served_priority, occupancy
//
// one item per cycle unless a result waits on a stalled out_ch: the whole chain
// compares against the new priority in parallel and shifts at the edge a beat is
// accepted, so its result is registered at that edge and shows on out_ch the next cycle
// in_ch.ready is high whenever the result register is empty or being taken
// synchronous active-low reset clears the count and the result valid;
// slot contents are never cleared, slots at or beyond the count are unread
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // entry count and result register
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [ID_W-1:0]  sid_r, sid_nxt;
  logic [PRI_W-1:0] spr_r, spr_nxt;
  logic [OCC_W-1:0] occ_r;

  logic      accept;
  logic      is_full, is_empty;
  cell_ctl_t ctl;

  entry_t    cell_q [DEPTH];
  logic      keep   [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CNT_W'(DEPTH));
  assign is_empty    = (count_r == '0);

  // decode the beat into a chain command and the result
  always_comb begin
    ctl.cmd           = CMD_HOLD;
    ctl.new_entry.id  = in_ch.entry_id;
    ctl.new_entry.pri = in_ch.entry_priority;
    count_nxt         = count_r;
    status_nxt        = ST_INSERTED;
    sid_nxt           = '0;
    spr_nxt           = '0;
    if (in_ch.opcode == OP_INSERT) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        ctl.cmd   = accept ? CMD_INSERT : CMD_HOLD;
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        ctl.cmd    = accept ? CMD_SERVE : CMD_HOLD;
        count_nxt  = count_r - 1'b1;
        status_nxt = ST_SERVED;
        sid_nxt    = cell_q[0].id;
        spr_nxt    = cell_q[0].pri;
      end
    end
  end

  // the chain; front of the queue sits in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_k;
    if (i == 0) begin : g_first
      // nothing ahead of the front: an insert that reaches it takes the new entry
      assign left_e = ctl.new_entry;
      assign left_k = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_k = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_q[i];
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .entry_q     (cell_q[i]),
      .keep        (keep[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) count_r <= count_nxt;
      if (accept) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      sid_r    <= sid_nxt;
      spr_r    <= spr_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.served_id       = sid_r;
  assign out_ch.served_priority = spr_r;
  assign out_ch.occupancy       = occ_r;

endmodule : stable_priority_queue_core
`default_nettype wire

>>> hw/rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// port-level checks on the stable priority queue, bound to the top level
// depends on spq_pkg, stable_priority_queue_core
module spq_checker
  import spq_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire status_t          status,
  input wire logic [ID_W-1:0]  served_id,
  input wire logic [PRI_W-1:0] served_priority,
  input wire logic [OCC_W-1:0] occupancy
);

  // a waiting result keeps its beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(served_id)
      && $stable(served_priority) && $stable(occupancy))
    else $error("result changed while stalled");

  // an empty result register never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

  // every accepted beat yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // only a serve carries an entry
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_SERVED |-> served_id == '0 && served_priority == '0)
    else $error("non-serve result carries entry data");

  // an empty report means nothing is stored
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> occupancy == '0)
    else $error("empty report with nonzero occupancy");

endmodule : spq_checker

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .served_id       (out_ch.served_id),
  .served_priority (out_ch.served_priority),
  .occupancy       (out_ch.occupancy)
);
`default_nettype wire
